// ===== hw/rtl/sbox_chain_password_hash_top_defines.svh =====
// assertion macros shared by the hash block rtl
// no dependencies; included by files that carry concurrent checks
`ifndef SBOX_CHAIN_PASSWORD_HASH_TOP_DEFINES_SVH
`define SBOX_CHAIN_PASSWORD_HASH_TOP_DEFINES_SVH

// same-cycle implication
`define SCH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sch_pkg.sv =====
// shared constants, types and s-box table for the password hash block
// no dependencies; used by every rtl module of the block by scoped names
package sch_pkg;

	localparam int KEY_BYTES    = 16;
	localparam int ROW_BYTES    = 16;
	localparam int MATRIX_BYTES = 48;
	localparam int MIX_PASSES   = 18;

	localparam int CNT_W  = $clog2(KEY_BYTES + 1);
	localparam int IDX_W  = $clog2(ROW_BYTES);
	localparam int POS_W  = $clog2(MATRIX_BYTES + 1);
	localparam int PASS_W = $clog2(MIX_PASSES);

	// configuration register indexes
	localparam logic REG_TARGET_FIRST  = 1'b0;
	localparam logic REG_TARGET_SECOND = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_MIX1,
		ST_RELOAD,
		ST_MIX2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       push;       // input transfer
		logic       last;       // transfer closes the password
		logic [7:0] data;       // byte of the transfer
		logic       pad;        // shift one pad byte in
		logic       shift_out;  // shift one key byte out
		logic       clear;      // drop the key for the next password
	} key_ctl_t;

	typedef struct packed {
		logic load;    // row0 zero, row1/row2 key, checksum walk
		logic mix;     // one chained s-box xor step
		logic reload;  // row1 = checksum, row2 = row0 ^ checksum
	} mix_ctl_t;

	typedef struct packed {
		logic mix_last;  // final step of the last pass
	} mix_sts_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hbd, 8'h56, 8'hea, 8'hf2, 8'ha2, 8'hf1, 8'hac, 8'h2a,
		8'hb0, 8'h93, 8'hd1, 8'h9c, 8'h1b, 8'h33, 8'hfd, 8'hd0,
		8'h30, 8'h04, 8'hb6, 8'hdc, 8'h7d, 8'hdf, 8'h32, 8'h4b,
		8'hf7, 8'hcb, 8'h45, 8'h9b, 8'h31, 8'hbb, 8'h21, 8'h5a,
		8'h41, 8'h9f, 8'he1, 8'hd9, 8'h4a, 8'h4d, 8'h9e, 8'hda,
		8'ha0, 8'h68, 8'h2c, 8'hc3, 8'h27, 8'h5f, 8'h80, 8'h36,
		8'h3e, 8'hee, 8'hfb, 8'h95, 8'h1a, 8'hfe, 8'hce, 8'ha8,
		8'h34, 8'ha9, 8'h13, 8'hf0, 8'ha6, 8'h3f, 8'hd8, 8'h0c,
		8'h78, 8'h24, 8'haf, 8'h23, 8'h52, 8'hc1, 8'h67, 8'h17,
		8'hf5, 8'h66, 8'h90, 8'he7, 8'he8, 8'h07, 8'hb8, 8'h60,
		8'h48, 8'he6, 8'h1e, 8'h53, 8'hf3, 8'h92, 8'ha4, 8'h72,
		8'h8c, 8'h08, 8'h15, 8'h6e, 8'h86, 8'h00, 8'h84, 8'hfa,
		8'hf4, 8'h7f, 8'h8a, 8'h42, 8'h19, 8'hf6, 8'hdb, 8'hcd,
		8'h14, 8'h8d, 8'h50, 8'h12, 8'hba, 8'h3c, 8'h06, 8'h4e,
		8'hec, 8'hb3, 8'h35, 8'h11, 8'ha1, 8'h88, 8'h8e, 8'h2b,
		8'h94, 8'h99, 8'hb7, 8'h71, 8'h74, 8'hd3, 8'he4, 8'hbf,
		8'h3a, 8'hde, 8'h96, 8'h0e, 8'hbc, 8'h0a, 8'hed, 8'h77,
		8'hfc, 8'h37, 8'h6b, 8'h03, 8'h79, 8'h89, 8'h62, 8'hc6,
		8'hd7, 8'hc0, 8'hd2, 8'h7c, 8'h6a, 8'h8b, 8'h22, 8'ha3,
		8'h5b, 8'h05, 8'h5d, 8'h02, 8'h75, 8'hd5, 8'h61, 8'he3,
		8'h18, 8'h8f, 8'h55, 8'h51, 8'had, 8'h1f, 8'h0b, 8'h5e,
		8'h85, 8'he5, 8'hc2, 8'h57, 8'h63, 8'hca, 8'h3d, 8'h6c,
		8'hb4, 8'hc5, 8'hcc, 8'h70, 8'hb2, 8'h91, 8'h59, 8'h0d,
		8'h47, 8'h20, 8'hc8, 8'h4f, 8'h58, 8'he0, 8'h01, 8'he2,
		8'h16, 8'h38, 8'hc4, 8'h6f, 8'h3b, 8'h0f, 8'h65, 8'h46,
		8'hbe, 8'h7e, 8'h2d, 8'h7b, 8'h82, 8'hf9, 8'h40, 8'hb5,
		8'h1d, 8'h73, 8'hf8, 8'heb, 8'h26, 8'hc7, 8'h87, 8'h97,
		8'h25, 8'h54, 8'hb1, 8'h28, 8'haa, 8'h98, 8'h9d, 8'ha5,
		8'h64, 8'h6d, 8'h7a, 8'hd4, 8'h10, 8'h81, 8'h44, 8'hef,
		8'h49, 8'hd6, 8'hae, 8'h2e, 8'hdd, 8'h76, 8'h5c, 8'h2f,
		8'ha7, 8'h1c, 8'hc9, 8'h09, 8'h69, 8'h9a, 8'h83, 8'hcf,
		8'h29, 8'h39, 8'hb9, 8'he9, 8'h4c, 8'hff, 8'h43, 8'hab
	};

endpackage

// ===== hw/rtl/sch_key_buf.sv =====
// key byte shift register: collects password bytes, pads, shifts key out
// depends on sch_pkg
module sch_key_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  sch_pkg::key_ctl_t ctl,
	output logic              key_full,
	output logic [7:0]        key_head
);

	logic [7:0]              key_q [sch_pkg::KEY_BYTES];
	logic [sch_pkg::CNT_W-1:0] count_q;
	logic [sch_pkg::CNT_W-1:0] count_after;
	logic [sch_pkg::CNT_W-1:0] pad_q;
	logic                    ended_q;
	logic                    store_en;
	logic                    shift_en;
	logic [7:0]              shift_in;

	assign key_full = (count_q == sch_pkg::CNT_W'(sch_pkg::KEY_BYTES));
	assign key_head = key_q[0];

	assign store_en = ctl.push && !ended_q && (ctl.data != 8'h00) &&
		(count_q < sch_pkg::CNT_W'(sch_pkg::KEY_BYTES));
	assign count_after = count_q + sch_pkg::CNT_W'(store_en);

	always_comb begin
		shift_en = store_en || ctl.pad || ctl.shift_out;
		if (store_en) begin
			shift_in = ctl.data;
		end else if (ctl.pad) begin
			shift_in = 8'(pad_q);
		end else begin
			shift_in = 8'h00;
		end
	end

	// new bytes enter at the tail; after sixteen shifts byte 0 is at the head
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < sch_pkg::KEY_BYTES - 1; i++) begin
				key_q[i] <= key_q[i+1];
			end
			key_q[sch_pkg::KEY_BYTES-1] <= shift_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && ctl.last) begin
			pad_q <= sch_pkg::CNT_W'(sch_pkg::KEY_BYTES) - count_after;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ended_q <= 1'b0;
		end else if (ctl.clear) begin
			count_q <= '0;
			ended_q <= 1'b0;
		end else begin
			if (store_en || ctl.pad) begin
				count_q <= count_q + sch_pkg::CNT_W'(1);
			end
			if (ctl.push && !ended_q && ctl.data == 8'h00) begin
				ended_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/sch_mix_core.sv =====
// 48-byte work matrix as three chained row shift registers, checksum row
// and the byte-serial chained s-box xor mixer; depends on sch_pkg
module sch_mix_core (
	input  logic              clk,
	input  logic              arst_n,
	input  sch_pkg::mix_ctl_t ctl,
	input  logic [7:0]        key_byte,
	output sch_pkg::mix_sts_t sts,
	output logic [127:0]      row0       // byte 0 in bits 127:120
);

	localparam int RB = sch_pkg::ROW_BYTES;

	logic [7:0] r0_q [RB];
	logic [7:0] r1_q [RB];
	logic [7:0] r2_q [RB];
	logic [7:0] cs_q [RB];
	logic [7:0] ck_prev_q;
	logic [7:0] prev_q;
	logic [sch_pkg::POS_W-1:0]  pos_q;
	logic [sch_pkg::PASS_W-1:0] pass_q;

	logic [sch_pkg::POS_W-1:0] down;
	logic [7:0] mix_idx;
	logic [7:0] mix_new;
	logic [7:0] ck_new;
	logic       pos_wrap;
	logic       pass_wrap;

	// byte at the head of row0 is the position being processed
	assign down     = sch_pkg::POS_W'(sch_pkg::MATRIX_BYTES) - pos_q;
	assign mix_idx  = 8'(down) + prev_q;
	assign mix_new  = r0_q[0] ^ sch_pkg::SBOX[mix_idx];
	assign ck_new   = sch_pkg::SBOX[key_byte ^ ck_prev_q];

	assign pos_wrap  = (pos_q == sch_pkg::POS_W'(sch_pkg::MATRIX_BYTES - 1));
	assign pass_wrap = (pass_q == sch_pkg::PASS_W'(sch_pkg::MIX_PASSES - 1));
	assign sts.mix_last = ctl.mix && pos_wrap && pass_wrap;

	always_comb begin
		for (int i = 0; i < RB; i++) begin
			row0[127 - 8*i -: 8] = r0_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mix) begin
			for (int i = 0; i < RB - 1; i++) begin
				r0_q[i] <= r0_q[i+1];
				r1_q[i] <= r1_q[i+1];
				r2_q[i] <= r2_q[i+1];
			end
			r0_q[RB-1] <= r1_q[0];
			r1_q[RB-1] <= r2_q[0];
			r2_q[RB-1] <= mix_new;
		end else if (ctl.load) begin
			for (int i = 0; i < RB - 1; i++) begin
				r0_q[i] <= r0_q[i+1];
				r1_q[i] <= r1_q[i+1];
				r2_q[i] <= r2_q[i+1];
				cs_q[i] <= cs_q[i+1];
			end
			r0_q[RB-1] <= 8'h00;
			r1_q[RB-1] <= key_byte;
			r2_q[RB-1] <= key_byte;
			cs_q[RB-1] <= ck_new;
		end else if (ctl.reload) begin
			// row0 and checksum rotate so both are intact afterwards
			for (int i = 0; i < RB - 1; i++) begin
				r0_q[i] <= r0_q[i+1];
				r1_q[i] <= r1_q[i+1];
				r2_q[i] <= r2_q[i+1];
				cs_q[i] <= cs_q[i+1];
			end
			r0_q[RB-1] <= r0_q[0];
			r1_q[RB-1] <= cs_q[0];
			r2_q[RB-1] <= r0_q[0] ^ cs_q[0];
			cs_q[RB-1] <= cs_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ck_prev_q <= '0;
			prev_q    <= '0;
			pos_q     <= '0;
			pass_q    <= '0;
		end else begin
			ck_prev_q <= ctl.load ? ck_new : 8'h00;
			if (ctl.mix) begin
				prev_q <= mix_new;
				if (pos_wrap) begin
					pos_q  <= '0;
					pass_q <= pass_wrap ? '0 : pass_q + sch_pkg::PASS_W'(1);
				end else begin
					pos_q <= pos_q + sch_pkg::POS_W'(1);
				end
			end else begin
				prev_q <= '0;
				pos_q  <= '0;
				pass_q <= '0;
			end
		end
	end

endmodule

// ===== hw/rtl/sbox_chain_password_hash_top.sv =====
// Password hash over a fixed 256-entry s-box. Password bytes enter one per
// transfer (tdata = byte, tlast = last byte of the password); a zero byte ends
// the key and at most 16 bytes are kept. After the transfer marked last the
// block stops taking input and works one matrix byte per cycle: padding (one
// pad byte per missing key byte, then a check that sees the key full), a sweep
// that loads the matrix and checksum, a mix (18 passes of 48 dependent s-box
// steps), a sweep that reloads the rows, a second mix and a hand-off, paced by
// the single byte-wide s-box chain; the hand-off waits while the previous
// result is still held unaccepted.
// The result holds the hash (bytes 0..7 in tdata[63:0], bytes 8..15 in
// tdata[127:64], byte 0 / byte 8 in the top bits of each half) and tuser[0]
// set when both halves equal the target registers; an output register holds
// it while the next password's bytes are taken.
// depends on sch_pkg, sch_key_buf, sch_mix_core and the assertion header
`include "sbox_chain_password_hash_top_defines.svh"

module sbox_chain_password_hash_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] key_byte
	input  logic         s_tlast,   // last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [63:0] hash_first_half, [127:64] hash_second_half
	output logic [0:0]   m_tuser,   // [0] hash_match
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data
);

	sch_pkg::state_t   state_q, state_d;
	sch_pkg::key_ctl_t key_ctl;
	sch_pkg::mix_ctl_t mix_ctl;
	sch_pkg::mix_sts_t mix_sts;

	logic [sch_pkg::IDX_W-1:0] cnt_q;
	logic                      cnt_last;
	logic                      key_full;
	logic [7:0]                key_head;
	logic [127:0]              row0;
	logic [63:0]               target_first_q;
	logic [63:0]               target_second_q;
	logic                      in_xfer;
	logic                      out_free;
	logic                      out_load;
	logic                      m_tvalid_q;
	logic [127:0]              m_tdata_q;
	logic                      m_match_q;

	sch_key_buf u_key_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (key_ctl),
		.key_full (key_full),
		.key_head (key_head)
	);

	sch_mix_core u_mix_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mix_ctl),
		.key_byte (key_head),
		.sts      (mix_sts),
		.row0     (row0)
	);

	assign s_tready = (state_q == sch_pkg::ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign cnt_last = (cnt_q == sch_pkg::IDX_W'(sch_pkg::ROW_BYTES - 1));

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sch_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d            = state_q;
		out_load           = 1'b0;
		key_ctl.push       = in_xfer;
		key_ctl.last       = s_tlast;
		key_ctl.data       = s_tdata;
		key_ctl.pad        = 1'b0;
		key_ctl.shift_out  = 1'b0;
		key_ctl.clear      = 1'b0;
		mix_ctl.load       = 1'b0;
		mix_ctl.mix        = 1'b0;
		mix_ctl.reload     = 1'b0;
		unique case (state_q)
			sch_pkg::ST_IDLE: begin
				if (in_xfer && s_tlast) begin
					state_d = sch_pkg::ST_PAD;
				end
			end
			sch_pkg::ST_PAD: begin
				if (key_full) begin
					state_d = sch_pkg::ST_LOAD;
				end else begin
					key_ctl.pad = 1'b1;
				end
			end
			sch_pkg::ST_LOAD: begin
				key_ctl.shift_out = 1'b1;
				mix_ctl.load      = 1'b1;
				if (cnt_last) begin
					state_d = sch_pkg::ST_MIX1;
				end
			end
			sch_pkg::ST_MIX1: begin
				mix_ctl.mix = 1'b1;
				if (mix_sts.mix_last) begin
					state_d = sch_pkg::ST_RELOAD;
				end
			end
			sch_pkg::ST_RELOAD: begin
				mix_ctl.reload = 1'b1;
				if (cnt_last) begin
					state_d = sch_pkg::ST_MIX2;
				end
			end
			sch_pkg::ST_MIX2: begin
				mix_ctl.mix = 1'b1;
				if (mix_sts.mix_last) begin
					state_d = sch_pkg::ST_DONE;
				end
			end
			sch_pkg::ST_DONE: begin
				if (out_free) begin
					out_load      = 1'b1;
					key_ctl.clear = 1'b1;
					state_d       = sch_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sch_pkg::ST_IDLE;
			end
		endcase
	end

	// row counter for the load and reload sweeps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == sch_pkg::ST_LOAD || state_q == sch_pkg::ST_RELOAD) begin
			cnt_q <= cnt_q + sch_pkg::IDX_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_first_q  <= '0;
			target_second_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sch_pkg::REG_TARGET_FIRST:  target_first_q  <= cfg_data;
				sch_pkg::REG_TARGET_SECOND: target_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {row0[63:0], row0[127:64]};
			m_match_q <= (row0[127:64] == target_first_q) &&
				(row0[63:0] == target_second_q);
		end
	end

	`SCH_ASSERT_NXT(a_last_starts_pad, clk, arst_n, in_xfer && s_tlast,
		state_q == sch_pkg::ST_PAD, "last transfer did not start padding")
	`SCH_ASSERT_NXT(a_load_to_mix, clk, arst_n, state_q == sch_pkg::ST_LOAD && cnt_last,
		state_q == sch_pkg::ST_MIX1, "load sweep did not hand over to the mix")
	`SCH_ASSERT_NXT(a_mix2_done, clk, arst_n, state_q == sch_pkg::ST_MIX2 && mix_sts.mix_last,
		state_q == sch_pkg::ST_DONE, "second mix end missed")
	`SCH_ASSERT_NXT(a_done_emits, clk, arst_n, state_q == sch_pkg::ST_DONE && out_free,
		m_tvalid && state_q == sch_pkg::ST_IDLE, "finished hash not presented")
	`SCH_ASSERT_IMP(a_mix_only_in_mix, clk, arst_n, mix_sts.mix_last,
		state_q == sch_pkg::ST_MIX1 || state_q == sch_pkg::ST_MIX2,
		"mix counter ran outside a mix phase")

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for sbox_chain_password_hash_top: password bytes go in as stream
// transfers; every digest that comes back is checked against a local s-box hash predictor.
// Depends on sch_pkg for the register indexes and on the rtl of the block.
`timescale 1ns / 1ps

module tb_top;

	localparam int LIMIT_CYCLES = 6_000_000;
	localparam int SETTLE_CYCLES = 1800;  // one full hash with margin
	localparam int HOLD_CYCLES = 6000;    // long output hold, spans a few hashes

	typedef struct packed {
		logic [63:0] first;
		logic [63:0] second;
		logic        match;
	} digest_t;

	typedef struct packed {
		logic [7:0] key_byte;
		logic       last;
		logic       known;      // match flag typed in below
		logic       match;
	} dir_row_t;

	localparam logic [7:0] HASH_SBOX [256] = '{
		8'hbd, 8'h56, 8'hea, 8'hf2, 8'ha2, 8'hf1, 8'hac, 8'h2a, 8'hb0, 8'h93, 8'hd1, 8'h9c,
		8'h1b, 8'h33, 8'hfd, 8'hd0, 8'h30, 8'h04, 8'hb6, 8'hdc, 8'h7d, 8'hdf, 8'h32, 8'h4b,
		8'hf7, 8'hcb, 8'h45, 8'h9b, 8'h31, 8'hbb, 8'h21, 8'h5a, 8'h41, 8'h9f, 8'he1, 8'hd9,
		8'h4a, 8'h4d, 8'h9e, 8'hda, 8'ha0, 8'h68, 8'h2c, 8'hc3, 8'h27, 8'h5f, 8'h80, 8'h36,
		8'h3e, 8'hee, 8'hfb, 8'h95, 8'h1a, 8'hfe, 8'hce, 8'ha8, 8'h34, 8'ha9, 8'h13, 8'hf0,
		8'ha6, 8'h3f, 8'hd8, 8'h0c, 8'h78, 8'h24, 8'haf, 8'h23, 8'h52, 8'hc1, 8'h67, 8'h17,
		8'hf5, 8'h66, 8'h90, 8'he7, 8'he8, 8'h07, 8'hb8, 8'h60, 8'h48, 8'he6, 8'h1e, 8'h53,
		8'hf3, 8'h92, 8'ha4, 8'h72, 8'h8c, 8'h08, 8'h15, 8'h6e, 8'h86, 8'h00, 8'h84, 8'hfa,
		8'hf4, 8'h7f, 8'h8a, 8'h42, 8'h19, 8'hf6, 8'hdb, 8'hcd, 8'h14, 8'h8d, 8'h50, 8'h12,
		8'hba, 8'h3c, 8'h06, 8'h4e, 8'hec, 8'hb3, 8'h35, 8'h11, 8'ha1, 8'h88, 8'h8e, 8'h2b,
		8'h94, 8'h99, 8'hb7, 8'h71, 8'h74, 8'hd3, 8'he4, 8'hbf, 8'h3a, 8'hde, 8'h96, 8'h0e,
		8'hbc, 8'h0a, 8'hed, 8'h77, 8'hfc, 8'h37, 8'h6b, 8'h03, 8'h79, 8'h89, 8'h62, 8'hc6,
		8'hd7, 8'hc0, 8'hd2, 8'h7c, 8'h6a, 8'h8b, 8'h22, 8'ha3, 8'h5b, 8'h05, 8'h5d, 8'h02,
		8'h75, 8'hd5, 8'h61, 8'he3, 8'h18, 8'h8f, 8'h55, 8'h51, 8'had, 8'h1f, 8'h0b, 8'h5e,
		8'h85, 8'he5, 8'hc2, 8'h57, 8'h63, 8'hca, 8'h3d, 8'h6c, 8'hb4, 8'hc5, 8'hcc, 8'h70,
		8'hb2, 8'h91, 8'h59, 8'h0d, 8'h47, 8'h20, 8'hc8, 8'h4f, 8'h58, 8'he0, 8'h01, 8'he2,
		8'h16, 8'h38, 8'hc4, 8'h6f, 8'h3b, 8'h0f, 8'h65, 8'h46, 8'hbe, 8'h7e, 8'h2d, 8'h7b,
		8'h82, 8'hf9, 8'h40, 8'hb5, 8'h1d, 8'h73, 8'hf8, 8'heb, 8'h26, 8'hc7, 8'h87, 8'h97,
		8'h25, 8'h54, 8'hb1, 8'h28, 8'haa, 8'h98, 8'h9d, 8'ha5, 8'h64, 8'h6d, 8'h7a, 8'hd4,
		8'h10, 8'h81, 8'h44, 8'hef, 8'h49, 8'hd6, 8'hae, 8'h2e, 8'hdd, 8'h76, 8'h5c, 8'h2f,
		8'ha7, 8'h1c, 8'hc9, 8'h09, 8'h69, 8'h9a, 8'h83, 8'hcf, 8'h29, 8'h39, 8'hb9, 8'he9,
		8'h4c, 8'hff, 8'h43, 8'hab
	};

	// target is zero after reset, so every digest here must miss it
	localparam dir_row_t DIRECTED_ROWS [24] = '{
		'{8'h00, 1'b1, 1'b1, 1'b0},   // empty password
		'{8'hff, 1'b1, 1'b1, 1'b0},   // lone byte riding on the last transfer
		'{8'h01, 1'b0, 1'b0, 1'b0},
		'{8'h80, 1'b0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 1'b0},   // terminator, rest is dropped
		'{8'h7f, 1'b0, 1'b0, 1'b0},
		'{8'hff, 1'b1, 1'b1, 1'b0},
		'{8'hff, 1'b0, 1'b0, 1'b0},   // overlong: 16 kept, last one dropped
		'{8'h01, 1'b0, 1'b0, 1'b0},
		'{8'h02, 1'b0, 1'b0, 1'b0},
		'{8'h04, 1'b0, 1'b0, 1'b0},
		'{8'h08, 1'b0, 1'b0, 1'b0},
		'{8'h10, 1'b0, 1'b0, 1'b0},
		'{8'h20, 1'b0, 1'b0, 1'b0},
		'{8'h40, 1'b0, 1'b0, 1'b0},
		'{8'h80, 1'b0, 1'b0, 1'b0},
		'{8'hfe, 1'b0, 1'b0, 1'b0},
		'{8'hfd, 1'b0, 1'b0, 1'b0},
		'{8'hfb, 1'b0, 1'b0, 1'b0},
		'{8'hf7, 1'b0, 1'b0, 1'b0},
		'{8'hef, 1'b0, 1'b0, 1'b0},
		'{8'hdf, 1'b0, 1'b0, 1'b0},
		'{8'hbf, 1'b0, 1'b0, 1'b0},
		'{8'h55, 1'b1, 1'b1, 1'b0}
	};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_we;
	logic         cfg_index;
	logic [63:0]  cfg_data;

	// match flag pinned by the directed table for the byte on offer
	logic         pin_known;
	logic         pin_match;

	logic [63:0]  target_first;
	logic [63:0]  target_second;
	digest_t      pending_digests[$];
	logic [7:0]   key_buf [16];
	int           key_len;
	logic         key_closed;

	int           cycles;
	int           errors;
	int           bytes_taken;
	int           hashes_seen;
	int           matches_seen;
	logic         tx_gaps;
	logic         rx_stalls;
	logic         long_hold;

	sbox_chain_password_hash_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// pads the key, runs the checksum walk and the two 18-pass mixes
	function automatic digest_t digest_of(input logic [7:0] key [16], input int len);
		logic [7:0] padded [16];
		logic [7:0] mat [48];
		logic [7:0] cks [16];
		logic [7:0] chain;
		logic [7:0] idx;
		digest_t    d;
		int         i;
		int         p;
		int         r;
		for (i = 0; i < 16; i++)
			padded[i] = (i < len) ? key[i] : 8'(16 - len);
		for (i = 0; i < 16; i++) begin
			mat[i] = 8'h00;
			mat[16 + i] = padded[i];
			mat[32 + i] = padded[i];
		end
		chain = 8'h00;
		for (i = 0; i < 16; i++) begin
			chain = HASH_SBOX[padded[i] ^ chain];
			cks[i] = chain;
		end
		for (r = 0; r < 2; r++) begin
			if (r == 1) begin
				for (i = 0; i < 16; i++) begin
					mat[16 + i] = cks[i];
					mat[32 + i] = mat[i] ^ cks[i];
				end
			end
			chain = 8'h00;
			for (p = 0; p < 18; p++) begin
				for (i = 0; i < 48; i++) begin
					idx = 8'(48 - i) + chain;
					chain = mat[i] ^ HASH_SBOX[idx];
					mat[i] = chain;
				end
			end
		end
		d.first = '0;
		d.second = '0;
		for (i = 0; i < 8; i++) begin
			d.first = {d.first[55:0], mat[i]};
			d.second = {d.second[55:0], mat[8 + i]};
		end
		d.match = 1'b0;
		return d;
	endfunction

	// key tracking, prediction and result checking, all on the rising edge
	always @(posedge clk) begin : monitor
		digest_t want;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (s_tvalid && s_tready) begin
				bytes_taken++;
				if (!key_closed) begin
					if (s_tdata == 8'h00)
						key_closed = 1'b1;
					else if (key_len < 16) begin
						key_buf[key_len] = s_tdata;
						key_len++;
					end
				end
				if (s_tlast) begin
					want = digest_of(key_buf, key_len);
					want.match = pin_known ? pin_match :
						(want.first == target_first && want.second == target_second);
					pending_digests.push_back(want);
					key_len = 0;
					key_closed = 1'b0;
				end
			end
			if (m_tvalid && m_tready) begin
				hashes_seen++;
				if (m_tuser[0])
					matches_seen++;
				if (pending_digests.size() == 0) begin
					errors++;
					$display("%0t: unexpected digest transfer, actual %h match %b",
						$time, m_tdata, m_tuser[0]);
				end else begin
					want = pending_digests.pop_front();
					if (m_tdata[63:0] !== want.first) begin
						errors++;
						$display("%0t: hash_first_half expected %h actual %h",
							$time, want.first, m_tdata[63:0]);
					end
					if (m_tdata[127:64] !== want.second) begin
						errors++;
						$display("%0t: hash_second_half expected %h actual %h",
							$time, want.second, m_tdata[127:64]);
					end
					if (m_tuser[0] !== want.match) begin
						errors++;
						$display("%0t: hash_match expected %b actual %b",
							$time, want.match, m_tuser[0]);
					end
				end
			end
		end
	end

	initial begin : watchdog
		while (cycles < LIMIT_CYCLES)
			@(posedge clk);
		$display("%0t: timeout with %0d digests outstanding", $time, pending_digests.size());
		$display("Test completed with failures");
		$finish;
	end

	// result side: random short stalls, plus one long hold on request
	initial begin : receiver
		int held;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				long_hold = 1'b0;
				m_tready <= 1'b1;
			end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 12)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// offer one byte and return on the falling edge after its transfer
	task automatic send_item(input logic [7:0] b, input logic last, input logic known,
		input logic match);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_tdata <= b;
		s_tlast <= last;
		pin_known <= known;
		pin_match <= match;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_password(input logic [7:0] pw [16], input int len);
		int i;
		for (i = 0; i < len; i++)
			send_item(pw[i], i == len - 1, 1'b0, 1'b0);
	endtask

	// mostly clean keys, some empty, overlong, cut short or raw noise
	task automatic send_random_password(output int n);
		logic [7:0] seq [$];
		int         kind;
		int         len;
		int         i;
		seq = {};
		kind = $urandom_range(0, 11);
		case (kind)
			0: begin
				seq.push_back(8'h00);
			end
			1: begin
				len = $urandom_range(17, 24);
				for (i = 0; i < len; i++)
					seq.push_back(8'($urandom_range(1, 255)));
			end
			2: begin
				len = $urandom_range(2, 20);
				for (i = 0; i < len; i++)
					seq.push_back(8'($urandom_range(1, 255)));
				seq[$urandom_range(0, len - 1)] = 8'h00;
			end
			3: begin
				len = $urandom_range(1, 20);
				for (i = 0; i < len; i++)
					seq.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
				len = $urandom_range(1, 16);
				for (i = 0; i < len; i++)
					seq.push_back(8'($urandom_range(1, 255)));
			end
		endcase
		for (i = 0; i < seq.size(); i++)
			send_item(seq[i], i == seq.size() - 1, 1'b0, 1'b0);
		n = seq.size();
	endtask

	task automatic send_random_passwords(input int n_items);
		int sent;
		int k;
		sent = 0;
		while (sent < n_items) begin
			send_random_password(k);
			sent += k;
		end
	endtask

	// called on a falling edge; leaves the block idle with nothing outstanding
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_digests.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == sch_pkg::REG_TARGET_FIRST)
			target_first = val;
		else
			target_second = val;
	endtask

	initial begin : stimulus
		logic [7:0] chosen_pw [16];
		digest_t    chosen;
		int         i;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		pin_known = 1'b0;
		pin_match = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sch_pkg::REG_TARGET_FIRST;
		cfg_data = '0;
		target_first = '0;
		target_second = '0;
		key_len = 0;
		key_closed = 1'b0;
		cycles = 0;
		errors = 0;
		bytes_taken = 0;
		hashes_seen = 0;
		matches_seen = 0;
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		long_hold = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table, no idling
		for (i = 0; i < 24; i++)
			send_item(DIRECTED_ROWS[i].key_byte, DIRECTED_ROWS[i].last,
				DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].match);
		wait_drained();

		// all-ones target, idling on both sides, long hold midway
		write_reg(sch_pkg::REG_TARGET_FIRST, '1);
		write_reg(sch_pkg::REG_TARGET_SECOND, '1);
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		send_random_passwords(80);
		long_hold = 1'b1;
		send_random_passwords(170);
		wait_drained();

		// target set to a known password, which is repeated among random ones
		for (i = 0; i < 16; i++)
			chosen_pw[i] = 8'($urandom_range(1, 255));
		chosen = digest_of(chosen_pw, 8);
		write_reg(sch_pkg::REG_TARGET_FIRST, chosen.first);
		write_reg(sch_pkg::REG_TARGET_SECOND, chosen.second);
		for (i = 0; i < 4; i++) begin
			send_password(chosen_pw, 8);
			send_random_passwords(50);
		end
		wait_drained();

		// only one half of the target agrees
		write_reg(sch_pkg::REG_TARGET_SECOND, ~chosen.second);
		send_password(chosen_pw, 8);
		wait_drained();
		write_reg(sch_pkg::REG_TARGET_FIRST, '0);
		write_reg(sch_pkg::REG_TARGET_SECOND, chosen.second);
		send_password(chosen_pw, 8);
		wait_drained();

		// zero target, then a quiet tail with no idling
		write_reg(sch_pkg::REG_TARGET_SECOND, '0);
		send_random_passwords(250);
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		send_random_passwords(100);
		wait_drained();

		$display("%0d digests checked from %0d byte transfers, %0d flagged as matching",
			hashes_seen, bytes_taken, matches_seen);
		$display("keys: empty, overlong, cut by a zero byte, noise; targets edited in phases");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
